>>> rtl/core/cau_pkg.sv
// Shared types and operation codes for the complex arithmetic unit.
// No dependencies.
package cau_pkg;

    // Operation selector codes.
    typedef logic [1:0] t_op;
    localparam t_op OP_ADD = 2'd0;
    localparam t_op OP_SUB = 2'd1;
    localparam t_op OP_MUL = 2'd2;
    localparam t_op OP_DIV = 2'd3;

    // Class of an item as decided by the front end.
    typedef struct packed {
        logic is_sub;
        logic is_mul;
        logic is_div;
        logic dbz;
    } t_cls;

endpackage

>>> rtl/core/cau_fifo.sv
// Small register queue between the front end and the execution pipeline.
// Depends on nothing; entries are opaque vectors.
module cau_fifo #(
    parameter int W  = 8,
    parameter int AW = 2
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic         o_full,
    output logic         o_empty,
    output logic [W-1:0] o_data
);
    localparam int DEPTH = 1 << AW;

    logic [W-1:0]  r_mem [DEPTH];
    logic [AW-1:0] r_wp, r_rp;
    logic [AW:0]   r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rp];

    // Storage has no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule

>>> rtl/core/cau_front.sv
// Front end: accepts items and classifies the operation.
// Depends on cau_pkg.
module cau_front #(
    parameter int DW = 16
) (
    input  logic          i_valid,
    output logic          o_stall,
    input  logic [1:0]    i_req_type,
    input  logic [DW-1:0] i_b_real,
    input  logic [DW-1:0] i_b_imag,
    input  logic          i_q_full,
    output logic          o_push,
    output cau_pkg::t_cls o_cls
);
    import cau_pkg::*;

    // An item is taken whenever the queue has room.
    assign o_stall = i_q_full;
    assign o_push  = i_valid && !i_q_full;

    // Decode the operation and flag a zero divisor.
    always_comb begin
        o_cls = '0;
        unique case (i_req_type)
            OP_ADD: o_cls = '0;
            OP_SUB: o_cls.is_sub = 1'b1;
            OP_MUL: o_cls.is_mul = 1'b1;
            OP_DIV: begin
                o_cls.is_div = 1'b1;
                o_cls.dbz    = (i_b_real == '0) && (i_b_imag == '0);
            end
            default: o_cls = '0;
        endcase
    end
endmodule

>>> rtl/core/cau_back.sv
// Execution pipeline: products, combination, bit-per-stage division, saturation.
// Depends on cau_pkg.
module cau_back #(
    parameter int DW = 16,
    parameter int F  = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_empty,
    input  cau_pkg::t_cls        i_cls,
    input  logic signed [DW-1:0] i_ar,
    input  logic signed [DW-1:0] i_ai,
    input  logic signed [DW-1:0] i_br,
    input  logic signed [DW-1:0] i_bi,
    output logic                 o_pop,
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [DW-1:0]        o_res_real,
    output logic [DW-1:0]        o_res_imag,
    output logic                 o_overflow,
    output logic                 o_div_by_zero
);
    import cau_pkg::*;

    localparam int PW = 2 * DW;
    localparam int VW = 2 * DW + 2;
    localparam int QB = DW + 1;
    localparam int NW = 3 * DW + 1;
    localparam int NS = QB + 2;
    localparam logic signed [VW-1:0] SAT_POS = VW'((65'd1 << (DW - 1)) - 65'd1);
    localparam logic signed [VW-1:0] SAT_NEG = -SAT_POS - VW'(1);

    typedef struct packed {
        logic                 vld;
        t_cls                 cls;
        logic signed [VW-1:0] v_re;
        logic signed [VW-1:0] v_im;
        logic                 neg_re;
        logic                 neg_im;
        logic [NW-1:0]        rem_re;
        logic [NW-1:0]        rem_im;
        logic [NW-1:0]        den;
        logic                 big_re;
        logic                 big_im;
        logic [QB-1:0]        q_re;
        logic [QB-1:0]        q_im;
    } t_st;

    logic en;
    logic r_pv;
    t_cls r_pcls;
    logic signed [PW-1:0] r_prr, r_pii, r_pri, r_pir, r_pbb, r_pdd;
    logic signed [DW:0]   r_pas_re, r_pas_im;
    t_st  r_st [NS];
    t_st  n_st [NS];
    logic r_ov;
    logic [DW-1:0] n_out_re, n_out_im;
    logic          n_out_ovf;

    // The whole pipeline moves unless a finished item is held at the output.
    assign en    = !(r_ov && i_stall);
    assign o_pop = en && !i_q_empty;
    assign o_valid = r_ov;

    // Product stage valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else if (en) begin
            r_pv <= o_pop;
        end
    end

    // Six multipliers plus the add or subtract of both parts.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pcls <= i_cls;
            r_prr  <= PW'(i_ar) * PW'(i_br);
            r_pii  <= PW'(i_ai) * PW'(i_bi);
            r_pri  <= PW'(i_ar) * PW'(i_bi);
            r_pir  <= PW'(i_ai) * PW'(i_br);
            r_pbb  <= PW'(i_br) * PW'(i_br);
            r_pdd  <= PW'(i_bi) * PW'(i_bi);
            r_pas_re <= i_cls.is_sub ? (DW+1)'(i_ar) - (DW+1)'(i_br)
                                     : (DW+1)'(i_ar) + (DW+1)'(i_br);
            r_pas_im <= i_cls.is_sub ? (DW+1)'(i_ai) - (DW+1)'(i_bi)
                                     : (DW+1)'(i_ai) + (DW+1)'(i_bi);
        end
    end

    // Combine products into results, or into scaled dividends and divisor.
    always_comb begin
        logic signed [PW:0] m_re, m_im, nr, ni;
        logic [PW:0] mag_re, mag_im;
        m_re = (PW+1)'(r_prr) - (PW+1)'(r_pii);
        m_im = (PW+1)'(r_pri) + (PW+1)'(r_pir);
        nr   = (PW+1)'(r_prr) + (PW+1)'(r_pii);
        ni   = (PW+1)'(r_pir) - (PW+1)'(r_pri);
        mag_re = nr[PW] ? -nr : nr;
        mag_im = ni[PW] ? -ni : ni;
        n_st[0]        = '0;
        n_st[0].vld    = r_pv;
        n_st[0].cls    = r_pcls;
        n_st[0].v_re   = r_pcls.is_mul ? VW'(m_re >>> F) : VW'(r_pas_re);
        n_st[0].v_im   = r_pcls.is_mul ? VW'(m_im >>> F) : VW'(r_pas_im);
        n_st[0].neg_re = nr[PW];
        n_st[0].neg_im = ni[PW];
        n_st[0].rem_re = NW'(mag_re) << F;
        n_st[0].rem_im = NW'(mag_im) << F;
        n_st[0].den    = NW'($unsigned(r_pbb)) + NW'($unsigned(r_pdd));
    end

    // Overflow check of the quotient, then one quotient bit per stage.
    for (genvar i = 1; i < NS; i++) begin : g_div
        if (i == 1) begin : g_big
            always_comb begin
                n_st[i] = r_st[i-1];
                n_st[i].big_re = r_st[i-1].rem_re >= (r_st[i-1].den << QB);
                n_st[i].big_im = r_st[i-1].rem_im >= (r_st[i-1].den << QB);
            end
        end else begin : g_bit
            always_comb begin
                logic [NW-1:0] cmp;
                cmp = r_st[i-1].den << (QB + 1 - i);
                n_st[i] = r_st[i-1];
                if (r_st[i-1].rem_re >= cmp) begin
                    n_st[i].rem_re = r_st[i-1].rem_re - cmp;
                    n_st[i].q_re[QB+1-i] = 1'b1;
                end
                if (r_st[i-1].rem_im >= cmp) begin
                    n_st[i].rem_im = r_st[i-1].rem_im - cmp;
                    n_st[i].q_im[QB+1-i] = 1'b1;
                end
            end
        end
    end

    // Pipeline registers; only the valid bits are reset.
    for (genvar i = 0; i < NS; i++) begin : g_reg
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_st[i].vld <= 1'b0;
            end else if (en) begin
                r_st[i] <= n_st[i];
            end
        end
    end

    // Select the final value and saturate it into the output register.
    always_comb begin
        logic signed [VW-1:0] vr, vi;
        logic [QB-1:0] qr, qi;
        t_st s;
        s  = r_st[NS-1];
        qr = s.big_re ? '1 : s.q_re;
        qi = s.big_im ? '1 : s.q_im;
        vr = s.v_re;
        vi = s.v_im;
        if (s.cls.is_div) begin
            vr = s.neg_re ? -VW'(qr) : VW'(qr);
            vi = s.neg_im ? -VW'(qi) : VW'(qi);
            if (s.cls.dbz) begin
                vr = '0;
                vi = '0;
            end
        end
        n_out_ovf = 1'b0;
        n_out_re  = DW'(vr);
        n_out_im  = DW'(vi);
        if (vr > SAT_POS) begin
            n_out_re = DW'(SAT_POS); n_out_ovf = 1'b1;
        end else if (vr < SAT_NEG) begin
            n_out_re = DW'(SAT_NEG); n_out_ovf = 1'b1;
        end
        if (vi > SAT_POS) begin
            n_out_im = DW'(SAT_POS); n_out_ovf = 1'b1;
        end else if (vi < SAT_NEG) begin
            n_out_im = DW'(SAT_NEG); n_out_ovf = 1'b1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (en) begin
            r_ov          <= r_st[NS-1].vld;
            o_res_real    <= n_out_re;
            o_res_imag    <= n_out_im;
            o_overflow    <= n_out_ovf;
            o_div_by_zero <= r_st[NS-1].cls.dbz;
        end
    end
endmodule

>>> rtl/core/complex_arithmetic_unit.sv
// Complex arithmetic unit: add, subtract, multiply and divide on signed
// fixed-point complex operands with saturation.
//
// Input channel: i_valid / o_stall with i_req_type and the four operand
// parts. Output channel: o_valid / i_stall with the result parts, the
// overflow flag and the divide-by-zero flag. An item moves at a clock edge
// where valid is high and stall is low.
// One item per cycle is taken and delivered in steady state while the
// receiver does not stall. Every operation passes through the divider,
// which resolves one quotient bit per pipeline stage. Items enter a
// four-entry queue; the execution pipeline drains it. When the receiver
// stalls while o_valid is high, the whole pipeline holds; the queue then
// fills and o_stall rises. Synchronous active-low reset empties the queue
// and the pipeline. Depends on cau_pkg, cau_front, cau_fifo and cau_back.
module complex_arithmetic_unit #(
    parameter int FRAC_BITS  = 8,
    parameter int DATA_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic [1:0]                   i_req_type,
    input  logic signed [DATA_WIDTH-1:0] i_a_real,
    input  logic signed [DATA_WIDTH-1:0] i_a_imag,
    input  logic signed [DATA_WIDTH-1:0] i_b_real,
    input  logic signed [DATA_WIDTH-1:0] i_b_imag,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_res_real,
    output logic signed [DATA_WIDTH-1:0] o_res_imag,
    output logic                         o_overflow,
    output logic                         o_div_by_zero
);
    import cau_pkg::*;

    localparam int DW = DATA_WIDTH;
    localparam int QW = 4 * DW + $bits(t_cls);

    logic          q_full, q_empty, push, pop;
    t_cls          cls, q_cls;
    logic [QW-1:0] q_din, q_dout;

    // Front end classifies items on the way into the queue.
    cau_front #(.DW(DW)) u_front (
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req_type (i_req_type),
        .i_b_real   (i_b_real),
        .i_b_imag   (i_b_imag),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cls      (cls)
    );

    assign q_din = {cls, i_a_real, i_a_imag, i_b_real, i_b_imag};
    assign q_cls = t_cls'(q_dout[QW-1 -: $bits(t_cls)]);

    // Decoupling queue.
    cau_fifo #(.W(QW), .AW(2)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_din),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_data  (q_dout)
    );

    // Execution pipeline.
    cau_back #(.DW(DW), .F(FRAC_BITS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_cls         (q_cls),
        .i_ar          ($signed(q_dout[4*DW-1 -: DW])),
        .i_ai          ($signed(q_dout[3*DW-1 -: DW])),
        .i_br          ($signed(q_dout[2*DW-1 -: DW])),
        .i_bi          ($signed(q_dout[DW-1 -: DW])),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_res_real    (o_res_real),
        .o_res_imag    (o_res_imag),
        .o_overflow    (o_overflow),
        .o_div_by_zero (o_div_by_zero)
    );
endmodule
